// ----- rtl/i2cmbe_pkg.sv -----
// Package for the I2C master bit engine: command codes, phase codes and the
// item and result structs used by the core and the top level.
// Depends on nothing.
package i2cmbe_pkg;

  localparam int unsigned PHASE_W = 5;
  localparam int unsigned CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
  localparam logic [PHASE_W-1:0] PH_START_A   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_START_B   = 5'd2;
  localparam logic [PHASE_W-1:0] PH_RESTART   = 5'd3;
  localparam logic [PHASE_W-1:0] PH_STOP_A    = 5'd4;
  localparam logic [PHASE_W-1:0] PH_STOP_B    = 5'd5;
  localparam logic [PHASE_W-1:0] PH_STOP_C    = 5'd6;
  localparam logic [PHASE_W-1:0] PH_WR_HI     = 5'd7;
  localparam logic [PHASE_W-1:0] PH_WR_LO     = 5'd8;
  localparam logic [PHASE_W-1:0] PH_WR_ACK_HI = 5'd9;
  localparam logic [PHASE_W-1:0] PH_WR_ACK_LO = 5'd10;
  localparam logic [PHASE_W-1:0] PH_RD_HI     = 5'd11;
  localparam logic [PHASE_W-1:0] PH_RD_LO     = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RD_ACK_HI = 5'd13;

  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [15:0] HALF_RESET    = 16'd5;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [7:0]       write_byte;
    logic             last_read;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       nack_received;
    logic [7:0] read_byte;
  } result_t;

endpackage

// ----- rtl/i2c_master_bit_engine_top.sv -----
// Top level of the I2C master bit engine: input register, bit engine core
// and result register. Depends on i2cmbe_pkg and i2cmbe_core.

// The engine drives SCL and SDA one half bit period at a time. Every input
// transfer is one tick: while idle it may carry a command (start, restart,
// stop, write a byte, read a byte), otherwise it only advances the current
// segment and supplies the sampled SDA level. Each input transfer yields
// exactly one result transfer with the pin levels, busy, done, the NACK flag
// of the latest write and the shift register. The engine takes one transfer
// per clock unless input stall holds it; a result passes through the input
// register and then the result register. The rate is set by the state update
// in the core, which reads the item in the input register and writes the
// engine state and the result register in the same cycle. Both channels use
// valid and stall; input stall rises only while a result waits under output
// stall and the input register is full.
// The half period register is written through cfg_we_i and cfg_wdata_i and
// should be changed only while the engine is idle; a value of zero acts as
// one, and values beyond the hold counter (DELAY_WIDTH bits) saturate.
module i2c_master_bit_engine_top #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  write_byte_i,
  input  logic        last_read_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_out_o,
  output logic        sda_drive_o,
  output logic        sda_level_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        nack_received_o,
  output logic [7:0]  read_byte_o
);

  logic                in_valid_q;
  i2cmbe_pkg::item_t   in_item_q;
  logic                out_valid_q;
  i2cmbe_pkg::result_t out_res_q;
  i2cmbe_pkg::result_t step_res;
  logic                advance;
  logic                step;

  // The pipeline moves whenever the result register is empty or drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload register, loaded on every accepted input transfer.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q.command    <= command_i;
      in_item_q.write_byte <= write_byte_i;
      in_item_q.last_read  <= last_read_i;
      in_item_q.sda_in     <= sda_in_i;
    end
  end

  i2cmbe_core #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (step),
    .item_i     (in_item_q),
    .res_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_out_o       = out_res_q.scl_out;
  assign sda_drive_o     = out_res_q.sda_drive;
  assign sda_level_o     = out_res_q.sda_level;
  assign busy_res_o      = out_res_q.busy_res;
  assign done_res_o      = out_res_q.done_res;
  assign nack_received_o = out_res_q.nack_received;
  assign read_byte_o     = out_res_q.read_byte;

  // A completing step leaves the engine idle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done reported while still busy");

  // A released SDA line always reads back high.
  a_release_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_drive_o |-> sda_level_o)
    else $error("SDA released with a low level");

  // Input stall only comes from a held, full result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && in_valid_q)
    else $error("input stalled without a blocked result");

  // A stepped item always shows up in the result register next cycle.
  a_step_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("stepped item lost");

endmodule

// ----- rtl/i2cmbe_core.sv -----
// Bit engine state and its one-step update for the I2C master.
// Depends on i2cmbe_pkg.
module i2cmbe_core #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 step_i,
  input  i2cmbe_pkg::item_t    item_i,
  output i2cmbe_pkg::result_t  res_o
);

  localparam int unsigned WIDE_W = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;

  logic [15:0]                     half_q;
  logic [i2cmbe_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic [3:0]                      bit_count_q, bit_count_d;
  logic [7:0]                      shift_q, shift_d;
  logic [DELAY_WIDTH-1:0]          delay_q, delay_d;
  logic                            scl_q, scl_d;
  logic                            sda_q, sda_d;
  logic                            sda_oe_q, sda_oe_d;
  logic                            ack_mode_q, ack_mode_d;
  logic                            nack_q, nack_d;
  logic                            done;
  logic                            finish;

  logic [15:0]             half_m1;
  logic [WIDE_W-1:0]       half_wide;
  logic [WIDE_W-1:0]       delay_max;
  logic [DELAY_WIDTH-1:0]  delay_load;
  logic [3:0]              bit_count_inc;
  logic [7:0]              shift_left;

  // Hold count for a new segment: half period minus one, zero taken as one,
  // saturated to the counter width.
  assign half_m1    = (half_q == 16'd0) ? 16'd0 : half_q - 16'd1;
  assign half_wide  = WIDE_W'(half_m1);
  assign delay_max  = WIDE_W'({DELAY_WIDTH{1'b1}});
  assign delay_load = DELAY_WIDTH'((half_wide > delay_max) ? delay_max : half_wide);

  assign bit_count_inc = bit_count_q + 4'd1;
  assign shift_left    = {shift_q[6:0], 1'b0};

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    delay_d     = delay_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    sda_oe_d    = sda_oe_q;
    ack_mode_d  = ack_mode_q;
    nack_d      = nack_q;
    finish      = 1'b0;

    if (phase_q == i2cmbe_pkg::PH_IDLE) begin
      case (item_i.command)
        i2cmbe_pkg::CMD_TICK: begin
        end
        i2cmbe_pkg::CMD_START: begin
          sda_d   = 1'b0;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_START_A;
        end
        i2cmbe_pkg::CMD_RESTART: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_RESTART;
        end
        i2cmbe_pkg::CMD_STOP: begin
          sda_d   = 1'b0;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_STOP_A;
        end
        i2cmbe_pkg::CMD_WRITE: begin
          shift_d     = item_i.write_byte;
          bit_count_d = 4'd0;
          sda_d       = item_i.write_byte[7];
          scl_d       = 1'b1;
          delay_d     = delay_load;
          phase_d     = i2cmbe_pkg::PH_WR_HI;
        end
        i2cmbe_pkg::CMD_READ: begin
          shift_d     = 8'd0;
          bit_count_d = 4'd0;
          ack_mode_d  = item_i.last_read;
          sda_d       = 1'b1;
          sda_oe_d    = 1'b0;
          scl_d       = 1'b1;
          delay_d     = delay_load;
          phase_d     = i2cmbe_pkg::PH_RD_HI;
        end
        default: begin
        end
      endcase
    end else if (delay_q != '0) begin
      delay_d = delay_q - DELAY_WIDTH'(1);
    end else begin
      case (phase_q)
        i2cmbe_pkg::PH_START_A: begin
          scl_d   = 1'b0;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_START_B;
        end
        i2cmbe_pkg::PH_STOP_A: begin
          scl_d   = 1'b1;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_STOP_B;
        end
        i2cmbe_pkg::PH_STOP_B: begin
          sda_d   = 1'b1;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_STOP_C;
        end
        i2cmbe_pkg::PH_WR_HI: begin
          scl_d   = 1'b0;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_WR_LO;
        end
        i2cmbe_pkg::PH_WR_LO: begin
          shift_d     = shift_left;
          bit_count_d = bit_count_inc;
          scl_d       = 1'b1;
          delay_d     = delay_load;
          if (bit_count_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
            sda_oe_d = 1'b0;
            sda_d    = 1'b1;
            phase_d  = i2cmbe_pkg::PH_WR_ACK_HI;
          end else begin
            sda_d   = shift_left[7];
            phase_d = i2cmbe_pkg::PH_WR_HI;
          end
        end
        i2cmbe_pkg::PH_WR_ACK_HI: begin
          nack_d  = item_i.sda_in;
          scl_d   = 1'b0;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_WR_ACK_LO;
        end
        i2cmbe_pkg::PH_WR_ACK_LO: begin
          sda_oe_d = 1'b1;
          sda_d    = 1'b0;
          finish   = 1'b1;
        end
        i2cmbe_pkg::PH_RD_HI: begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          scl_d   = 1'b0;
          delay_d = delay_load;
          phase_d = i2cmbe_pkg::PH_RD_LO;
        end
        i2cmbe_pkg::PH_RD_LO: begin
          bit_count_d = bit_count_inc;
          scl_d       = 1'b1;
          delay_d     = delay_load;
          if (bit_count_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
            sda_oe_d = 1'b1;
            sda_d    = ack_mode_q;
            phase_d  = i2cmbe_pkg::PH_RD_ACK_HI;
          end else begin
            phase_d = i2cmbe_pkg::PH_RD_HI;
          end
        end
        i2cmbe_pkg::PH_RD_ACK_HI: begin
          scl_d  = 1'b0;
          sda_d  = 1'b0;
          finish = 1'b1;
        end
        i2cmbe_pkg::PH_START_B, i2cmbe_pkg::PH_RESTART, i2cmbe_pkg::PH_STOP_C: begin
          finish = 1'b1;
        end
        default: begin
          // Codes that no sequence reaches simply end the command.
          finish = 1'b1;
        end
      endcase
    end

    done = finish;
    if (finish) begin
      phase_d     = i2cmbe_pkg::PH_IDLE;
      bit_count_d = 4'd0;
      delay_d     = '0;
    end
  end

  always_comb begin
    res_o.scl_out       = scl_d;
    res_o.sda_drive     = sda_oe_d;
    res_o.sda_level     = sda_d;
    res_o.busy_res      = (phase_d != i2cmbe_pkg::PH_IDLE);
    res_o.done_res      = done;
    res_o.nack_received = nack_d;
    res_o.read_byte     = shift_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= i2cmbe_pkg::HALF_RESET;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cmbe_pkg::PH_IDLE;
      bit_count_q <= 4'd0;
      shift_q     <= 8'd0;
      delay_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      sda_oe_q    <= 1'b1;
      ack_mode_q  <= 1'b0;
      nack_q      <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      delay_q     <= delay_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      sda_oe_q    <= sda_oe_d;
      ack_mode_q  <= ack_mode_d;
      nack_q      <= nack_d;
    end
  end

endmodule

// ----- tb/i2cmbe_checker.sv -----
// Checker for the I2C master bit engine: follows both transfer channels and
// the half period register, predicts every result and compares it field by field.
// Depends on i2cmbe_pkg.
module i2cmbe_checker #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [7:0]  write_byte_i,
  input  logic        last_read_i,
  input  logic        sda_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        scl_out_i,
  input  logic        sda_drive_i,
  input  logic        sda_level_i,
  input  logic        busy_res_i,
  input  logic        done_res_i,
  input  logic        nack_received_i,
  input  logic [7:0]  read_byte_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned HOLD_MAX = (64'd1 << DELAY_WIDTH) - 64'd1;

  // Our own copy of the engine state and of the half period register.
  logic [15:0]                        half_q;
  logic [i2cmbe_pkg::PHASE_W-1:0]     phase_q;
  logic [3:0]                         bit_cnt_q;
  logic [7:0]                         shreg_q;
  logic [DELAY_WIDTH-1:0]             hold_q;
  logic                               scl_q;
  logic                               sda_q;
  logic                               sda_oe_q;
  logic                               ack_level_q;
  logic                               nack_q;

  i2cmbe_pkg::result_t pin_state_q[$];
  int unsigned         fails;

  // Enter a segment: the entry step counts as the first of the half period.
  function automatic void enter_segment(logic [i2cmbe_pkg::PHASE_W-1:0] next);
    longint unsigned h;
    h = (half_q == 16'd0) ? 64'd1 : 64'(half_q);
    h = h - 64'd1;
    if (h > HOLD_MAX) h = HOLD_MAX;
    hold_q  = h[DELAY_WIDTH-1:0];
    phase_q = next;
  endfunction

  function automatic void end_command();
    phase_q   = i2cmbe_pkg::PH_IDLE;
    bit_cnt_q = 4'd0;
    hold_q    = '0;
  endfunction

  // One tick of the engine for an accepted input transfer.
  function automatic i2cmbe_pkg::result_t predict_pins(i2cmbe_pkg::item_t it);
    i2cmbe_pkg::result_t r;
    logic                done;
    done = 1'b0;
    if (phase_q == i2cmbe_pkg::PH_IDLE) begin
      case (it.command)
        i2cmbe_pkg::CMD_START: begin
          sda_q = 1'b0;
          enter_segment(i2cmbe_pkg::PH_START_A);
        end
        i2cmbe_pkg::CMD_RESTART: begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          enter_segment(i2cmbe_pkg::PH_RESTART);
        end
        i2cmbe_pkg::CMD_STOP: begin
          sda_q = 1'b0;
          enter_segment(i2cmbe_pkg::PH_STOP_A);
        end
        i2cmbe_pkg::CMD_WRITE: begin
          shreg_q   = it.write_byte;
          bit_cnt_q = 4'd0;
          sda_q     = it.write_byte[7];
          scl_q     = 1'b1;
          enter_segment(i2cmbe_pkg::PH_WR_HI);
        end
        i2cmbe_pkg::CMD_READ: begin
          shreg_q     = 8'd0;
          bit_cnt_q   = 4'd0;
          ack_level_q = it.last_read;
          sda_q       = 1'b1;
          sda_oe_q    = 1'b0;
          scl_q       = 1'b1;
          enter_segment(i2cmbe_pkg::PH_RD_HI);
        end
        default: begin
        end
      endcase
    end else if (hold_q != '0) begin
      hold_q = hold_q - 1'b1;
    end else begin
      case (phase_q)
        i2cmbe_pkg::PH_START_A: begin
          scl_q = 1'b0;
          enter_segment(i2cmbe_pkg::PH_START_B);
        end
        i2cmbe_pkg::PH_STOP_A: begin
          scl_q = 1'b1;
          enter_segment(i2cmbe_pkg::PH_STOP_B);
        end
        i2cmbe_pkg::PH_STOP_B: begin
          sda_q = 1'b1;
          enter_segment(i2cmbe_pkg::PH_STOP_C);
        end
        i2cmbe_pkg::PH_WR_HI: begin
          scl_q = 1'b0;
          enter_segment(i2cmbe_pkg::PH_WR_LO);
        end
        i2cmbe_pkg::PH_WR_LO: begin
          shreg_q   = {shreg_q[6:0], 1'b0};
          bit_cnt_q = bit_cnt_q + 4'd1;
          scl_q     = 1'b1;
          if (bit_cnt_q >= i2cmbe_pkg::BITS_PER_BYTE) begin
            sda_oe_q = 1'b0;
            sda_q    = 1'b1;
            enter_segment(i2cmbe_pkg::PH_WR_ACK_HI);
          end else begin
            sda_q = shreg_q[7];
            enter_segment(i2cmbe_pkg::PH_WR_HI);
          end
        end
        i2cmbe_pkg::PH_WR_ACK_HI: begin
          nack_q = it.sda_in;
          scl_q  = 1'b0;
          enter_segment(i2cmbe_pkg::PH_WR_ACK_LO);
        end
        i2cmbe_pkg::PH_WR_ACK_LO: begin
          sda_oe_q = 1'b1;
          sda_q    = 1'b0;
          end_command();
          done = 1'b1;
        end
        i2cmbe_pkg::PH_RD_HI: begin
          shreg_q = {shreg_q[6:0], it.sda_in};
          scl_q   = 1'b0;
          enter_segment(i2cmbe_pkg::PH_RD_LO);
        end
        i2cmbe_pkg::PH_RD_LO: begin
          bit_cnt_q = bit_cnt_q + 4'd1;
          scl_q     = 1'b1;
          if (bit_cnt_q >= i2cmbe_pkg::BITS_PER_BYTE) begin
            sda_oe_q = 1'b1;
            sda_q    = ack_level_q;
            enter_segment(i2cmbe_pkg::PH_RD_ACK_HI);
          end else begin
            enter_segment(i2cmbe_pkg::PH_RD_HI);
          end
        end
        i2cmbe_pkg::PH_RD_ACK_HI: begin
          scl_q = 1'b0;
          sda_q = 1'b0;
          end_command();
          done = 1'b1;
        end
        default: begin
          // The restart segment and the last start and stop segments end here.
          end_command();
          done = 1'b1;
        end
      endcase
    end
    r.scl_out       = scl_q;
    r.sda_drive     = sda_oe_q;
    r.sda_level     = sda_q;
    r.busy_res      = (phase_q != i2cmbe_pkg::PH_IDLE);
    r.done_res      = done;
    r.nack_received = nack_q;
    r.read_byte     = shreg_q;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    i2cmbe_pkg::item_t   it;
    i2cmbe_pkg::result_t want;
    i2cmbe_pkg::result_t got;
    if (!rst_ni) begin
      half_q      = i2cmbe_pkg::HALF_RESET;
      phase_q     = i2cmbe_pkg::PH_IDLE;
      bit_cnt_q   = 4'd0;
      shreg_q     = 8'd0;
      hold_q      = '0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      sda_oe_q    = 1'b1;
      ack_level_q = 1'b0;
      nack_q      = 1'b0;
      pin_state_q.delete();
      fails       = 0;
    end else begin
      if (cfg_we_i) half_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        it.command    = command_i;
        it.write_byte = write_byte_i;
        it.last_read  = last_read_i;
        it.sda_in     = sda_in_i;
        pin_state_q.push_back(predict_pins(it));
      end
      if (out_valid_i && !out_stall_i) begin
        got.scl_out       = scl_out_i;
        got.sda_drive     = sda_drive_i;
        got.sda_level     = sda_level_i;
        got.busy_res      = busy_res_i;
        got.done_res      = done_res_i;
        got.nack_received = nack_received_i;
        got.read_byte     = read_byte_i;
        if (pin_state_q.size() == 0) begin
          $error("result transfer with no prediction waiting");
          fails++;
        end else begin
          want = pin_state_q.pop_front();
          check_field("scl_out", want.scl_out, got.scl_out);
          check_field("sda_drive", want.sda_drive, got.sda_drive);
          check_field("sda_level", want.sda_level, got.sda_level);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("nack_received", want.nack_received, got.nack_received);
          check_field("read_byte", want.read_byte, got.read_byte);
        end
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= pin_state_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the I2C master bit engine testbench: clock, reset, stimulus, stall
// pressure and the verdict. Depends on i2cmbe_pkg, i2cmbe_checker and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes that the engine does not know and treats as a plain tick.
  localparam logic [i2cmbe_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [i2cmbe_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  // How the SDA level of each transfer is chosen.
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = i2cmbe_pkg::CMD_TICK;
  logic [7:0]  write_byte = 8'd0;
  logic        last_read = 1'b0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_out;
  logic        sda_drive;
  logic        sda_level;
  logic        busy_res;
  logic        done_res;
  logic        nack_received;
  logic [7:0]  read_byte;

  int unsigned fail_count;
  int unsigned outstanding;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // Half period the engine actually uses: a register value of zero acts as one.
  int unsigned half_eff = i2cmbe_pkg::HALF_RESET;

  always #6ns clk = ~clk;

  i2c_master_bit_engine_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .write_byte_i   (write_byte),
    .last_read_i    (last_read),
    .sda_in_i       (sda_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .scl_out_o      (scl_out),
    .sda_drive_o    (sda_drive),
    .sda_level_o    (sda_level),
    .busy_res_o     (busy_res),
    .done_res_o     (done_res),
    .nack_received_o(nack_received),
    .read_byte_o    (read_byte)
  );

  i2cmbe_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .write_byte_i   (write_byte),
    .last_read_i    (last_read),
    .sda_in_i       (sda_in),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .scl_out_i      (scl_out),
    .sda_drive_i    (sda_drive),
    .sda_level_i    (sda_level),
    .busy_res_i     (busy_res),
    .done_res_i     (done_res),
    .nack_received_i(nack_received),
    .read_byte_i    (read_byte),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // The receiver stalls at random; the current pressure phase sets the odds.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic pick_sda(int sel);
    if (sel == SDA_LOW) return 1'b0;
    if (sel == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  // Present one input transfer and hold it until the engine takes it. A random
  // number of idle cycles may come first. On return we sit in the time step of
  // the accepting edge, so the caller may present the next transfer at once.
  task automatic send_item(logic [2:0] cmd, logic [7:0] wb, logic last, logic sda);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    write_byte <= wb;
    last_read  <= last;
    sda_in     <= sda;
    do @(posedge clk); while (in_stall);
  endtask

  // Issue one command and then exactly as many ticks as it needs to finish,
  // so the next command finds the engine idle. Ticks carry random bytes and
  // flags; with noise_pct they also carry random command codes, which the busy
  // engine must ignore. The last tick is the step on which the command
  // completes; done_cmd puts a command there, which must be ignored as well.
  task automatic run_command(logic [2:0] cmd, logic [7:0] wb, logic last, int sda_sel,
                             int unsigned noise_pct, logic [2:0] done_cmd);
    int unsigned segments;
    int unsigned ticks;
    logic [2:0]  tick_cmd;
    case (cmd)
      i2cmbe_pkg::CMD_START:   segments = 2;
      i2cmbe_pkg::CMD_RESTART: segments = 1;
      i2cmbe_pkg::CMD_STOP:    segments = 3;
      i2cmbe_pkg::CMD_WRITE:   segments = 2 * i2cmbe_pkg::BITS_PER_BYTE + 2;
      i2cmbe_pkg::CMD_READ:    segments = 2 * i2cmbe_pkg::BITS_PER_BYTE + 1;
      default:                 segments = 0;
    endcase
    ticks = segments * half_eff;
    send_item(cmd, wb, last, pick_sda(sda_sel));
    for (int unsigned i = 0; i < ticks; i++) begin
      tick_cmd = i2cmbe_pkg::CMD_TICK;
      if (i == ticks - 1) tick_cmd = done_cmd;
      else if ($urandom_range(99) < noise_pct) tick_cmd = 3'($urandom_range(7));
      send_item(tick_cmd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                pick_sda(sda_sel));
    end
  endtask

  // Wait until every predicted result has been delivered and the pipeline has
  // drained, then write a new half period while the engine sits idle. The
  // first edge lets the checker count the transfer accepted just before.
  task automatic set_half_period(logic [15:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    half_eff = (value == 16'd0) ? 1 : value;
  endtask

  // A random command code that leaves an idle engine idle.
  function automatic logic [2:0] idle_code();
    case ($urandom_range(2))
      0:       return i2cmbe_pkg::CMD_TICK;
      1:       return CMD_UNUSED_A;
      default: return CMD_UNUSED_B;
    endcase
  endfunction

  // One bus transaction with random content: start, address byte, one to three
  // data bytes in the direction the address asks for, then stop or restart.
  // Stray commands on busy ticks and on idle steps act as noise.
  task automatic run_transaction();
    logic [7:0]  addr;
    int unsigned n_bytes;
    addr    = 8'($urandom_range(255));
    n_bytes = $urandom_range(1, 3);
    run_command(i2cmbe_pkg::CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
                SDA_RAND, 5, i2cmbe_pkg::CMD_TICK);
    run_command(i2cmbe_pkg::CMD_WRITE, addr, 1'($urandom_range(1)), SDA_RAND, 5,
                i2cmbe_pkg::CMD_TICK);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(9) == 0)
        send_item(idle_code(), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      if (addr[0])
        run_command(i2cmbe_pkg::CMD_READ, 8'($urandom_range(255)), (i == n_bytes - 1),
                    SDA_RAND, 5,
                    ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
                                               i2cmbe_pkg::CMD_TICK);
      else
        run_command(i2cmbe_pkg::CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    SDA_RAND, 5,
                    ($urandom_range(9) == 0) ? 3'($urandom_range(7)) :
                                               i2cmbe_pkg::CMD_TICK);
    end
    if ($urandom_range(4) == 0)
      run_command(i2cmbe_pkg::CMD_RESTART, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  SDA_RAND, 5, i2cmbe_pkg::CMD_TICK);
    else
      run_command(i2cmbe_pkg::CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  SDA_RAND, 5, i2cmbe_pkg::CMD_TICK);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first start runs on the half period left by reset.
    run_command(i2cmbe_pkg::CMD_START, 8'h00, 1'b0, SDA_HIGH, 0, i2cmbe_pkg::CMD_TICK);
    // A zero half period must behave as one tick per half bit.
    set_half_period(16'd0);
    // Byte extremes; SDA held low gives an ACK, held high a NACK.
    run_command(i2cmbe_pkg::CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 0, i2cmbe_pkg::CMD_TICK);
    run_command(i2cmbe_pkg::CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0, i2cmbe_pkg::CMD_TICK);
    // Reads of all ones answered with ACK and of all zeros answered with NACK.
    run_command(i2cmbe_pkg::CMD_READ, 8'hFF, 1'b0, SDA_HIGH, 0, i2cmbe_pkg::CMD_TICK);
    run_command(i2cmbe_pkg::CMD_READ, 8'h00, 1'b1, SDA_LOW, 0, i2cmbe_pkg::CMD_TICK);
    run_command(i2cmbe_pkg::CMD_RESTART, 8'hA5, 1'b1, SDA_RAND, 0, i2cmbe_pkg::CMD_TICK);
    run_command(i2cmbe_pkg::CMD_STOP, 8'h5A, 1'b0, SDA_RAND, 0, i2cmbe_pkg::CMD_TICK);
    // Unknown codes on an idle engine do nothing.
    send_item(CMD_UNUSED_A, 8'hFF, 1'b1, 1'b0);
    send_item(CMD_UNUSED_B, 8'h00, 1'b0, 1'b1);
    send_item(i2cmbe_pkg::CMD_TICK, 8'hFF, 1'b1, 1'b1);
    // Every busy tick carries a command; the one on the completing step too.
    run_command(i2cmbe_pkg::CMD_WRITE, 8'h96, 1'b0, SDA_RAND, 100, i2cmbe_pkg::CMD_READ);
    run_command(i2cmbe_pkg::CMD_START, 8'h3C, 1'b1, SDA_RAND, 100, i2cmbe_pkg::CMD_WRITE);

    // Random transactions under each pressure phase and several half periods.
    idle_pct = 0;
    stall_pct = 0;
    set_half_period(16'd1);
    repeat (3) run_transaction();

    idle_pct = 56;
    stall_pct = 0;
    set_half_period(16'd2);
    repeat (3) run_transaction();

    idle_pct = 0;
    stall_pct = 56;
    set_half_period(16'd0);
    repeat (3) run_transaction();

    idle_pct = 23;
    stall_pct = 23;
    set_half_period(16'd1);
    repeat (3) run_transaction();

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8ms;
    $display("tb: failure");
    $finish;
  end

endmodule
